// File: rtl/core/diag_gaussian_log_score_top_macros.svh
// Assertion macros for the Gaussian log-likelihood scorer.
// Used by diag_gaussian_log_score_top.sv in rtl/core; depends on nothing else.
`ifndef DIAG_GAUSSIAN_LOG_SCORE_TOP_MACROS_SVH
`define DIAG_GAUSSIAN_LOG_SCORE_TOP_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define DGLS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define DGLS_ASSERT(lbl, prop, msg) \
  `DGLS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/core/dgls_pkg.sv
// Shared types and constants of the Gaussian log-likelihood scorer.
// Used by every module in rtl/core; depends on nothing else.
package dgls_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 256;
  localparam int unsigned FEAT_DIM_DEF    = 64;
  localparam int unsigned DIMS_W          = 7;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 7'd64;
  localparam int unsigned ACC_W           = 64;
  localparam int unsigned FRAC_DROP       = 13;
  localparam int unsigned SCORE_W         = 48;

  typedef enum logic [2:0] {
    REQ_WR_MEAN  = 3'd0,
    REQ_WR_IVAR  = 3'd1,
    REQ_WR_LNORM = 3'd2,
    REQ_WR_FEAT  = 3'd3,
    REQ_SCORE    = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         entry_index;
    logic [5:0]         dim_index;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0]                entry_index_out;
    logic signed [SCORE_W-1:0] score;
    logic                      saturated;
  } res_t;

  // Write selects into the stores.
  typedef struct packed {
    logic mean;
    logic ivar;
    logic lnorm;
    logic feat;
  } wr_sel_t;

  // One dimension's slot travelling down the multiply-accumulate pipeline.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic active;
  } tok_t;

endpackage

// File: rtl/core/dgls_store.sv
// Model and feature stores: mean, inverse variance, log constant and feature memories.
// Single write port, one registered read port each; depends on dgls_pkg.
module dgls_store #(
  parameter int unsigned NUM_ENTRIES = dgls_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned FEAT_DIM    = dgls_pkg::FEAT_DIM_DEF,
  localparam int unsigned E_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
  localparam int unsigned D_W = (FEAT_DIM > 1) ? $clog2(FEAT_DIM) : 1
) (
  input  logic                clk_i,
  input  dgls_pkg::wr_sel_t   wr_sel_i,
  input  logic [E_W-1:0]      wr_entry_i,
  input  logic [D_W-1:0]      wr_dim_i,
  input  logic [31:0]         wr_data_i,
  input  logic                rd_en_i,
  input  logic [E_W-1:0]      rd_entry_i,
  input  logic [D_W-1:0]      rd_dim_i,
  output logic [15:0]         mean_o,
  output logic [15:0]         ivar_o,
  output logic [15:0]         feat_o,
  output logic [31:0]         lnorm_o
);
  import dgls_pkg::*;

  localparam int unsigned A_W       = E_W + D_W;
  localparam int unsigned MEM_DEPTH = NUM_ENTRIES * (2 ** D_W);

  logic [15:0] mean_mem  [MEM_DEPTH];
  logic [15:0] ivar_mem  [MEM_DEPTH];
  logic [31:0] lnorm_mem [NUM_ENTRIES];
  logic [15:0] feat_mem  [FEAT_DIM];

  logic [A_W-1:0] wr_addr;
  logic [A_W-1:0] rd_addr;
  wr_sel_t        sel;

  assign wr_addr = {wr_entry_i, wr_dim_i};
  assign rd_addr = {rd_entry_i, rd_dim_i};
  assign sel     = wr_sel_i;

  always_ff @(posedge clk_i) begin
    if (sel.mean) begin
      mean_mem[wr_addr] <= wr_data_i[15:0];
    end
    if (rd_en_i) begin
      mean_o <= mean_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel.ivar) begin
      ivar_mem[wr_addr] <= wr_data_i[15:0];
    end
    if (rd_en_i) begin
      ivar_o <= ivar_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel.lnorm) begin
      lnorm_mem[wr_entry_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      lnorm_o <= lnorm_mem[rd_entry_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel.feat) begin
      feat_mem[wr_dim_i] <= wr_data_i[15:0];
    end
    if (rd_en_i) begin
      feat_o <= feat_mem[rd_dim_i];
    end
  end

endmodule

// File: rtl/core/dgls_mac.sv
// Multiply-accumulate pipeline and final rounding and clipping of the score.
// Takes registered store data one dimension per cycle; depends on dgls_pkg.
module dgls_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dgls_pkg::tok_t                tok_i,
  input  logic [15:0]                   mean_i,
  input  logic [15:0]                   ivar_i,
  input  logic [15:0]                   feat_i,
  input  logic [31:0]                   lnorm_i,
  output logic                          done_o,
  output logic [dgls_pkg::SCORE_W-1:0]  score_o,
  output logic                          sat_o
);
  import dgls_pkg::*;

  tok_t tok_a_q, tok_b_q, tok_c_q, tok_d_q;

  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic [16:0]        mag_b_q;
  logic [15:0]        iv_b_q, iv_c_q;
  logic [33:0]        sq_c_q;
  logic [49:0]        prod_d_q;
  logic [ACC_W-1:0]   acc_q;
  logic               fin_q;
  logic [ACC_W-1:0]   t_q;
  logic               t_vld_q;
  logic [ACC_W-1:0]   ln_ext;
  logic signed [ACC_W-1:0] sh;
  logic [ACC_W-SCORE_W:0]  hi;
  logic               clip;
  logic [SCORE_W-1:0] score_d;
  logic [SCORE_W-1:0] score_q;
  logic               sat_q;
  logic               done_q;

  // Token stages carry control; reset clears them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_a_q <= '0;
      tok_b_q <= '0;
      tok_c_q <= '0;
      tok_d_q <= '0;
      fin_q   <= 1'b0;
      t_vld_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      tok_a_q <= tok_i;
      tok_b_q <= tok_a_q;
      tok_c_q <= tok_b_q;
      tok_d_q <= tok_c_q;
      fin_q   <= tok_d_q.vld & tok_d_q.last;
      t_vld_q <= fin_q;
      done_q  <= t_vld_q;
    end
  end

  assign diff = $signed({feat_i[15], feat_i}) - $signed({mean_i[15], mean_i});
  assign mag  = diff[16] ? 17'(-diff) : 17'(diff);

  always_ff @(posedge clk_i) begin
    mag_b_q  <= tok_a_q.active ? mag : '0;
    iv_b_q   <= ivar_i;
    sq_c_q   <= 34'(mag_b_q) * 34'(mag_b_q);
    iv_c_q   <= iv_b_q;
    prod_d_q <= 50'(sq_c_q) * 50'(iv_c_q);
    if (tok_d_q.vld) begin
      acc_q <= (tok_d_q.first ? '0 : acc_q) + ACC_W'(prod_d_q);
    end
    if (fin_q) begin
      t_q <= (ln_ext << FRAC_DROP) - acc_q;
    end
    if (t_vld_q) begin
      score_q <= score_d;
      sat_q   <= clip;
    end
  end

  assign ln_ext = {{(ACC_W-32){lnorm_i[31]}}, lnorm_i};

  // The arithmetic shift rounds toward minus infinity.
  assign sh   = $signed(t_q) >>> FRAC_DROP;
  assign hi   = sh[ACC_W-1:SCORE_W-1];
  assign clip = ~((&hi) | ~(|hi));

  always_comb begin
    if (!clip) begin
      score_d = sh[SCORE_W-1:0];
    end else if (sh[ACC_W-1]) begin
      score_d = {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      score_d = {1'b0, {(SCORE_W-1){1'b1}}};
    end
  end

  assign done_o  = done_q;
  assign score_o = score_q;
  assign sat_o   = sat_q;

endmodule

// File: rtl/core/diag_gaussian_log_score_top.sv
// A score request for entry e walks the dimensions in use, n = min(dims_in_use, FEAT_DIM),
// one per cycle through the store read port and a multiply-accumulate pipeline, and delivers
// its result once the walk has drained from the pipeline; busy is high until that result
// strobe, and a new request may be taken in the strobe cycle itself. Write requests are taken
// while idle and may follow one another back to back. The result appears for exactly one
// cycle on res_o, marked by res_strobe_o, and cannot be held off by the receiver. Requests
// naming an entry beyond the stored range, unknown request types and writes to a dimension
// beyond the stored range are dropped without a result. Scoring an entry whose mean, inverse
// variance or constant was never written gives an undefined score.
// Top level: sequencer and dims register; depends on dgls_pkg, dgls_store, dgls_mac and the macros header.
`include "diag_gaussian_log_score_top_macros.svh"

module diag_gaussian_log_score_top #(
  parameter int unsigned NUM_ENTRIES = dgls_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned FEAT_DIM    = dgls_pkg::FEAT_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  dgls_pkg::req_t              req_i,
  input  logic                        cfg_we_i,
  input  logic [dgls_pkg::DIMS_W-1:0] cfg_wdata_i,
  output logic                        res_strobe_o,
  output dgls_pkg::res_t              res_o
);
  import dgls_pkg::*;

  localparam int unsigned E_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned D_W   = (FEAT_DIM > 1) ? $clog2(FEAT_DIM) : 1;
  localparam int unsigned EX_W  = (E_W > 8) ? E_W : 8;
  localparam int unsigned DX_W  = (D_W > 6) ? D_W : 6;
  localparam int unsigned N_W   = $clog2(FEAT_DIM + 1);
  localparam int unsigned NX_W  = (N_W > DIMS_W) ? N_W : DIMS_W;

  state_e            state_q, state_d;
  logic [D_W-1:0]    cnt_q, cnt_d;
  logic [D_W-1:0]    last_q;
  logic              active_q;
  logic [7:0]        entry_q;
  logic [DIMS_W-1:0] dims_q;

  logic              go_idle;
  logic              accept;
  logic              entry_ok;
  logic              dim_ok;
  logic              score_go;
  req_type_e         rtype;
  wr_sel_t           wr_sel;
  logic [EX_W-1:0]   req_entry_x;
  logic [DX_W-1:0]   req_dim_x;
  logic [EX_W-1:0]   cur_entry_x;
  logic [NX_W-1:0]   dims_x;
  logic [NX_W-1:0]   n_x;
  logic [NX_W-1:0]   n_m1;
  tok_t              tok;
  logic              rd_en;

  logic [15:0]        mean_rd, ivar_rd, feat_rd;
  logic [31:0]        lnorm_rd;
  logic               mac_done;
  logic [SCORE_W-1:0] mac_score;
  logic               mac_sat;

  // Request decode.
  assign rtype       = req_type_e'(req_i.req_type);
  assign req_entry_x = EX_W'(req_i.entry_index);
  assign req_dim_x   = DX_W'(req_i.dim_index);
  assign cur_entry_x = EX_W'(entry_q);
  assign entry_ok    = 32'(req_i.entry_index) < NUM_ENTRIES;
  assign dim_ok      = 32'(req_i.dim_index) < FEAT_DIM;

  assign go_idle  = (state_q == ST_IDLE) || ((state_q == ST_DRAIN) && mac_done);
  assign busy     = ~go_idle;
  assign accept   = start & go_idle;
  assign score_go = accept & entry_ok & (rtype == REQ_SCORE);

  assign wr_sel.mean  = accept & entry_ok & dim_ok & (rtype == REQ_WR_MEAN);
  assign wr_sel.ivar  = accept & entry_ok & dim_ok & (rtype == REQ_WR_IVAR);
  assign wr_sel.lnorm = accept & entry_ok & (rtype == REQ_WR_LNORM);
  assign wr_sel.feat  = accept & entry_ok & dim_ok & (rtype == REQ_WR_FEAT);

  // Dimensions summed: the register clipped to the stored width.
  assign dims_x = NX_W'(dims_q);
  assign n_x    = (dims_x > NX_W'(FEAT_DIM)) ? NX_W'(FEAT_DIM) : dims_x;
  assign n_m1   = n_x - NX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_RESET;
    end else if (cfg_we_i) begin
      dims_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (score_go) begin
      entry_q  <= req_i.entry_index;
      active_q <= (n_x != '0);
      last_q   <= (n_x != '0) ? n_m1[D_W-1:0] : '0;
    end
  end

  // With no dimension in use one inactive slot still runs, so the constant alone is scored.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    tok     = '0;
    case (state_q)
      ST_IDLE: begin
        state_d = ST_IDLE;
      end
      ST_RUN: begin
        tok.vld    = 1'b1;
        tok.first  = (cnt_q == '0);
        tok.last   = (cnt_q == last_q);
        tok.active = active_q;
        if (cnt_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + D_W'(1);
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (score_go) begin
      state_d = ST_RUN;
      cnt_d   = '0;
    end
  end

  assign rd_en = (state_q != ST_IDLE);

  dgls_store #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .FEAT_DIM    (FEAT_DIM)
  ) u_store (
    .clk_i      (clk_i),
    .wr_sel_i   (wr_sel),
    .wr_entry_i (req_entry_x[E_W-1:0]),
    .wr_dim_i   (req_dim_x[D_W-1:0]),
    .wr_data_i  (req_i.value),
    .rd_en_i    (rd_en),
    .rd_entry_i (cur_entry_x[E_W-1:0]),
    .rd_dim_i   (cnt_q),
    .mean_o     (mean_rd),
    .ivar_o     (ivar_rd),
    .feat_o     (feat_rd),
    .lnorm_o    (lnorm_rd)
  );

  dgls_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tok_i   (tok),
    .mean_i  (mean_rd),
    .ivar_i  (ivar_rd),
    .feat_i  (feat_rd),
    .lnorm_i (lnorm_rd),
    .done_o  (mac_done),
    .score_o (mac_score),
    .sat_o   (mac_sat)
  );

  assign res_strobe_o          = mac_done;
  assign res_o.entry_index_out = entry_q;
  assign res_o.score           = mac_score;
  assign res_o.saturated       = mac_sat;

  `DGLS_ASSERT(a_done_in_drain, mac_done |-> (state_q == ST_DRAIN), "Result strobe seen outside the drain state.")
  `DGLS_ASSERT(a_score_starts_run, score_go |=> (state_q == ST_RUN), "An accepted score request did not start the walk.")
  `DGLS_ASSERT(a_cnt_in_range, (state_q == ST_RUN) |-> (cnt_q <= last_q), "Dimension counter ran past the last dimension.")

endmodule
